### hdl/tccs_pkg.sv
// shared types, codes and helpers for the text console cursor and scroll block
`default_nettype none

package tccs_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int CNT_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_INDEX_W = 1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SET = 1'b1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic TARGET_CELL = 1'b0;
  localparam logic TARGET_CRTC = 1'b1;

  localparam logic [15:0] CRTC_START_HI = 16'h000C;
  localparam logic [15:0] CRTC_START_LO = 16'h000D;
  localparam logic [15:0] CRTC_CURSOR_HI = 16'h000E;
  localparam logic [15:0] CRTC_CURSOR_LO = 16'h000F;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_ENABLE = 1'b1;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd10;
  localparam logic SCROLL_ENABLE_RESET = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [7:0] new_row;
    logic [6:0] new_col;
  } in_item_t;

  typedef struct packed {
    logic        target;
    logic [15:0] address;
    logic [15:0] data;
    logic        scroll_event;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] text_color;
    logic       scroll_enable;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]                  cnt;
    out_item_t [MAX_RESULTS-1:0]       slot;
  } burst_t;

  function automatic out_item_t make_out(input logic target, input logic [15:0] address,
                                         input logic [15:0] data, input logic scroll_event,
                                         input logic last);
    out_item_t r;
    r.target = target;
    r.address = address;
    r.data = data;
    r.scroll_event = scroll_event;
    r.last = last;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/tccs_exec.sv
// cursor and window state with the single-pass update that builds one result burst
`default_nettype none

module tccs_exec #(
  parameter int WIDTH = 80,
  parameter int HEIGHT = 25,
  parameter int MAX_ROWS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire tccs_pkg::in_item_t item,
  input  wire tccs_pkg::cfg_t    cfg,
  output tccs_pkg::burst_t       burst
);
  import tccs_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(WIDTH);
  localparam int CW1 = CW + 1;
  localparam int RW1 = RW + 1;
  localparam int PW = RW + CW + 1;

  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] wt_r, wt_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic [CW1-1:0] col_step;
  logic           adv;
  logic           char_wr;
  logic           scroll;
  logic [PW-1:0]  cell_pos, cur_pos, start_pos;
  logic [15:0]    cur16, start16;
  logic [CNT_W-1:0] k;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    wt_nxt = wt_r;
    col_step = '0;
    adv = 1'b0;
    char_wr = 1'b0;
    scroll = 1'b0;
    if (item.kind == KIND_SET) begin
      row_nxt = (16'(item.new_row) > 16'(MAX_ROWS - 1)) ? RW'(MAX_ROWS - 1) : RW'(item.new_row);
      col_nxt = (16'(item.new_col) > 16'(WIDTH - 1)) ? CW'(WIDTH - 1) : CW'(item.new_col);
    end else begin
      if (item.char_code == CHAR_CR) begin
        col_step = '0;
      end else if (item.char_code == CHAR_LF) begin
        col_step = '0;
        adv = 1'b1;
      end else begin
        col_step = CW1'(col_r) + 1'b1;
        char_wr = 1'b1;
      end
      if (col_step >= CW1'(WIDTH)) begin
        col_step = '0;
        adv = 1'b1;
      end
      if (adv && row_r != RW'(MAX_ROWS - 1)) begin
        row_nxt = row_r + 1'b1;
      end
      col_nxt = CW'(col_step);
      if (cfg.scroll_enable) begin
        if (row_nxt < wt_r) begin
          scroll = 1'b1;
          wt_nxt = wt_r - 1'b1;
        end else if (RW1'(row_nxt) > RW1'(wt_r) + RW1'(HEIGHT - 1)) begin
          scroll = 1'b1;
          wt_nxt = wt_r + 1'b1;
        end
      end
    end
  end

  assign cell_pos = PW'(row_r) * PW'(WIDTH) + PW'(col_r);
  assign cur_pos = PW'(row_nxt) * PW'(WIDTH) + PW'(col_nxt);
  assign start_pos = PW'(wt_nxt) * PW'(WIDTH);
  assign cur16 = 16'(cur_pos);
  assign start16 = 16'(start_pos);

  always_comb begin
    burst = '0;
    k = '0;
    if (char_wr) begin
      burst.slot[k] = make_out(TARGET_CELL, 16'(cell_pos), {cfg.text_color, item.char_code},
                               1'b0, 1'b0);
      k = k + 1'b1;
    end
    if (scroll) begin
      burst.slot[k] = make_out(TARGET_CRTC, CRTC_START_LO, {8'h00, start16[7:0]}, 1'b1, 1'b0);
      k = k + 1'b1;
      burst.slot[k] = make_out(TARGET_CRTC, CRTC_START_HI, {8'h00, start16[15:8]}, 1'b1, 1'b0);
      k = k + 1'b1;
    end
    burst.slot[k] = make_out(TARGET_CRTC, CRTC_CURSOR_LO, {8'h00, cur16[7:0]}, 1'b0, 1'b0);
    k = k + 1'b1;
    burst.slot[k] = make_out(TARGET_CRTC, CRTC_CURSOR_HI, {8'h00, cur16[15:8]}, 1'b0, 1'b1);
    k = k + 1'b1;
    burst.cnt = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      wt_r <= '0;
    end else if (load) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      wt_r <= wt_nxt;
    end
  end

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(row_r) && $stable(col_r) && $stable(wt_r))
    else $error("cursor state changed without an item");

  a_set_two: assert property (@(posedge clk) disable iff (!rst_n)
    load && item.kind == KIND_SET |-> burst.cnt == CNT_W'(2))
    else $error("set-cursor item must give two results");

  a_wt_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (wt_r == $past(wt_r)) || (wt_r == $past(wt_r) + 1'b1) ||
             (wt_r == $past(wt_r) - 1'b1))
    else $error("window moved more than one line");

endmodule

`default_nettype wire

### hdl/tccs_burst.sv
// result register that holds one item's burst and hands it out one result per cycle while out_ready is high
`default_nettype none

module tccs_burst (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire tccs_pkg::burst_t  burst,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tccs_pkg::out_item_t    out_data
);
  import tccs_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  out_item_t [MAX_RESULTS-1:0] slot_r, slot_nxt;
  logic pop;

  assign out_valid = (cnt_r != '0);
  assign out_data = slot_r[0];
  assign pop = out_valid && out_ready;
  assign free = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    slot_nxt = slot_r;
    if (load) begin
      cnt_nxt = burst.cnt;
      slot_nxt = burst.slot;
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  a_load_size: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> burst.cnt >= CNT_W'(2) && burst.cnt <= CNT_W'(MAX_RESULTS))
    else $error("burst size out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (cnt_r == CNT_W'(1))))
    else $error("last flag does not match the final result");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !load |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("result count did not drop by one");

endmodule

`default_nettype wire

### hdl/text_console_cursor_scroll.sv
// text console writer: input item register, cursor/window update, result burst output
// an accepted item passes through the input item register, then the burst register, before its first result is offered
// each item gives 2 to 5 results; the next item can load as the last result of the burst is taken
// the burst register drains one result per cycle while out_ready is high; the next item waits in the input register
// reset: cursor row, column and window top go to 0, text_color to 10, scroll_enable to 1
`default_nettype none

module text_console_cursor_scroll #(
  parameter int WIDTH = 80,
  parameter int HEIGHT = 25,
  parameter int MAX_ROWS = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire tccs_pkg::in_item_t                    in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output tccs_pkg::out_item_t                        out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [tccs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [tccs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import tccs_pkg::*;

  logic      item_v_r;
  in_item_t  item_r;
  cfg_t      cfg_r;
  logic      free;
  logic      load;
  burst_t    burst;

  assign load = item_v_r && free;
  assign in_ready = !item_v_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_v_r <= 1'b1;
    end else if (load) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_color <= TEXT_COLOR_RESET;
      cfg_r.scroll_enable <= SCROLL_ENABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXT_COLOR:    cfg_r.text_color <= cfg_data;
        CFG_SCROLL_ENABLE: cfg_r.scroll_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tccs_exec #(
    .WIDTH(WIDTH),
    .HEIGHT(HEIGHT),
    .MAX_ROWS(MAX_ROWS)
  ) u_exec (
    .clk(clk),
    .rst_n(rst_n),
    .load(load),
    .item(item_r),
    .cfg(cfg_r),
    .burst(burst)
  );

  tccs_burst u_burst (
    .clk(clk),
    .rst_n(rst_n),
    .load(load),
    .burst(burst),
    .free(free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

`default_nettype wire
